[hw/rtl/slave_clock_pulse_sequencer_defines.svh]
// ----------------------------------------------------------------------------
// Slave clock pulse sequencer assertion macros
// Shared assertion macros for the sequencer. Defining NO_ASSERTIONS leaves
// every use empty.
// ----------------------------------------------------------------------------
`ifndef SLAVE_CLOCK_PULSE_SEQUENCER_DEFINES_SVH
`define SLAVE_CLOCK_PULSE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge except while reset is asserted.
`define SCP_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Checked on every clock edge, including during reset.
`define SCP_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCP_ASSERT(name, prop, msg)
`define SCP_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

[hw/rtl/scp_pkg.sv]
// ----------------------------------------------------------------------------
// Slave clock pulse sequencer package
// Types, command and register codes and constants of the drive sequencer.
// ----------------------------------------------------------------------------
package scp_pkg;

	localparam int TimerWidth = 16;
	localparam int OutWidth   = 16;

	// Timer counter mask, cut to the width of the reload output.
	localparam logic [OutWidth-1:0] TimerMaskOut =
		OutWidth'((64'd1 << TimerWidth) - 64'd1);

	localparam logic [15:0] ButtonBaseTicks = 16'd8000;

	// Commands of an input item.
	localparam logic [1:0] CMD_TIMER  = 2'd0;
	localparam logic [1:0] CMD_COMP   = 2'd1;
	localparam logic [1:0] CMD_BUTTON = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_PERIOD      = 3'd0;
	localparam logic [2:0] REG_PULSE       = 3'd1;
	localparam logic [2:0] REG_CHARGE      = 3'd2;
	localparam logic [2:0] REG_TRIM_PERIOD = 3'd3;
	localparam logic [2:0] REG_TRIM_STEP   = 3'd4;
	localparam logic [2:0] REG_TRIM_OFFSET = 3'd5;
	localparam logic [2:0] REG_TRIM_SIGN   = 3'd6;
	localparam logic [2:0] REG_MODE        = 3'd7;

	// Configuration reset values.
	localparam logic [15:0] PeriodReset = 16'd30720;
	localparam logic [15:0] PulseReset  = 16'd50;
	localparam logic [4:0]  ModeReset   = 5'd24;

	typedef enum logic [1:0] {
		PH_INITIAL = 2'd0,
		PH_IDLE    = 2'd1,
		PH_CHARGE  = 2'd2,
		PH_PULSE   = 2'd3
	} phase_t;

	typedef struct packed {
		logic gate_a;
		logic gate_b;
		logic boost_low;
		logic boost_high;
		logic cutoff;
	} pins_t;

endpackage

[hw/rtl/slave_clock_pulse_sequencer.sv]
// ----------------------------------------------------------------------------
// Slave clock pulse sequencer
// Phase machine of a slave-clock driver: timer reloads and drive pin levels.
// ----------------------------------------------------------------------------
// Usage:
// Input items (cmd, timer_count) arrive on item_valid / item_stall. An item
// is accepted at a clock edge with item_valid high and item_stall low. It is
// held in an input register, and the whole phase step is computed from that
// register into the result register.
// Each input item gives exactly one result item on result_valid /
// result_stall. One item per cycle is sustained while result_stall is low;
// the step logic between the input and result registers sets that figure.
// When the receiver stalls, the result register holds its item and the input
// register can still take one more item; item_stall rises only when both
// are full.
// Configuration registers are written through cfg_we, cfg_index and cfg_data.
// The user must write them only while the block is idle; this is not enforced.
// Reset puts the configuration at its defaults, the phase at initial, the pin
// state low, the trim accumulator at zero and both registers empty.
// ----------------------------------------------------------------------------
`include "slave_clock_pulse_sequencer_defines.svh"

module slave_clock_pulse_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] timer_count,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] reload_value,
	output logic        reload_written,
	output logic        gate_a,
	output logic        gate_b,
	output logic        boost_low,
	output logic        boost_high,
	output logic        cutoff,
	output logic        comparator_on,
	output logic [1:0]  phase
);

	// Configuration registers.
	logic [15:0] period_q, pulse_q, charge_q, trim_period_q, trim_step_q, trim_offset_q;
	logic [1:0]  trim_sign_q;
	logic [4:0]  mode_q;

	// Input register.
	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic [15:0] count_s1;

	// Sequencer state.
	scp_pkg::phase_t phase_q, phase_nxt;
	logic            toggle_q, toggle_nxt;
	logic            armed_q, armed_nxt;
	logic [15:0]     ext_q, ext_nxt;
	logic [15:0]     meas_q, meas_nxt;
	logic [16:0]     acc_q, acc_nxt;
	scp_pkg::pins_t  pins_q, pins_nxt;

	// Result register.
	logic            res_valid_q;
	logic [15:0]     res_reload_q;
	logic            res_written_q;
	scp_pkg::pins_t  res_pins_q;
	logic            res_armed_q;
	scp_pkg::phase_t res_phase_q;

	logic        advance, accept, step;
	logic        dual, alt;
	logic        pulse_step;
	logic [15:0] reload, ext_sum;
	logic        written;
	logic [17:0] acc_sum;
	logic        trim_on, trim_hit;
	logic [15:0] trim_corr, period_value;

	assign advance    = !res_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	assign step       = valid_s1 && advance;

	assign dual = mode_q[0];
	assign alt  = mode_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q      <= scp_pkg::PeriodReset;
			pulse_q       <= scp_pkg::PulseReset;
			charge_q      <= '0;
			trim_period_q <= '0;
			trim_step_q   <= '0;
			trim_offset_q <= '0;
			trim_sign_q   <= '0;
			mode_q        <= scp_pkg::ModeReset;
		end else if (cfg_we) begin
			case (cfg_index)
				scp_pkg::REG_PERIOD:      period_q      <= cfg_data;
				scp_pkg::REG_PULSE:       pulse_q       <= cfg_data;
				scp_pkg::REG_CHARGE:      charge_q      <= cfg_data;
				scp_pkg::REG_TRIM_PERIOD: trim_period_q <= cfg_data;
				scp_pkg::REG_TRIM_STEP:   trim_step_q   <= cfg_data;
				scp_pkg::REG_TRIM_OFFSET: trim_offset_q <= cfg_data;
				scp_pkg::REG_TRIM_SIGN:   trim_sign_q   <= cfg_data[1:0];
				scp_pkg::REG_MODE:        mode_q        <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Input register: takes an item whenever it is empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd;
			count_s1 <= timer_count;
		end
	end

	// A pulse step runs on a timer match in the pulse phase, and in single-cell
	// mode also in the charge phase when no charge time is set.
	always_comb begin
		pulse_step = 1'b0;
		if (cmd_s1 == scp_pkg::CMD_TIMER) begin
			if (phase_q == scp_pkg::PH_PULSE) begin
				pulse_step = 1'b1;
			end else if (!dual && phase_q == scp_pkg::PH_CHARGE && charge_q == '0) begin
				pulse_step = 1'b1;
			end
		end
	end

	// Next phase.
	always_comb begin
		phase_nxt = phase_q;
		if (cmd_s1 == scp_pkg::CMD_TIMER) begin
			case (phase_q)
				scp_pkg::PH_IDLE:   phase_nxt = scp_pkg::PH_CHARGE;
				scp_pkg::PH_CHARGE: phase_nxt = pulse_step ? scp_pkg::PH_IDLE
				                                           : scp_pkg::PH_PULSE;
				scp_pkg::PH_PULSE:  phase_nxt = scp_pkg::PH_IDLE;
				default:            phase_nxt = dual ? scp_pkg::PH_CHARGE
				                                     : scp_pkg::PH_IDLE;
			endcase
		end
	end

	// Trim correction of the period reload. The accumulator sum is formed at
	// full width so that a stale accumulator above the wrap value still works.
	always_comb begin
		trim_on  = trim_period_q != '0;
		acc_sum  = {1'b0, acc_q} + {2'b00, trim_step_q};
		trim_hit = trim_on && (acc_sum >= {2'b00, trim_period_q});
		trim_corr = trim_offset_q +
			(trim_hit ? {{14{trim_sign_q[1]}}, trim_sign_q} : 16'd0);
		ext_sum = pulse_q + charge_q + ext_q + (dual ? meas_q : 16'd0) + 16'd1;
		period_value = period_q - ext_sum + trim_corr;
	end

	// Result and state outputs of one step.
	always_comb begin
		reload     = '0;
		written    = 1'b0;
		toggle_nxt = toggle_q;
		armed_nxt  = armed_q;
		ext_nxt    = ext_q;
		meas_nxt   = meas_q;
		acc_nxt    = acc_q;
		pins_nxt   = pins_q;
		case (cmd_s1)
			scp_pkg::CMD_TIMER: begin
				written = 1'b1;
				if (pulse_step) begin
					reload = pulse_q - 16'd1;
					if (dual) begin
						armed_nxt           = 1'b0;
						pins_nxt.boost_high = 1'b1;
						pins_nxt.cutoff     = 1'b0;
					end else begin
						pins_nxt.cutoff    = 1'b1;
						pins_nxt.boost_low = 1'b0;
					end
					// With alternating polarity the first pulse goes to gate B.
					if (!alt || toggle_q) begin
						pins_nxt.gate_a = 1'b1;
					end else begin
						pins_nxt.gate_b = 1'b1;
					end
					if (alt) begin
						toggle_nxt = !toggle_q;
					end
				end else begin
					case (phase_q)
						scp_pkg::PH_IDLE: begin
							reload          = period_value;
							ext_nxt         = '0;
							pins_nxt.gate_a = 1'b0;
							pins_nxt.gate_b = 1'b0;
							if (!dual) begin
								pins_nxt.boost_low = 1'b1;
								armed_nxt          = 1'b1;
							end
							if (trim_on) begin
								acc_nxt = trim_hit ? 17'(acc_sum - {2'b00, trim_period_q})
								                   : acc_sum[16:0];
							end
						end
						scp_pkg::PH_CHARGE: begin
							if (dual) begin
								reload              = scp_pkg::TimerMaskOut;
								armed_nxt           = 1'b1;
								pins_nxt.cutoff     = 1'b1;
								pins_nxt.boost_high = 1'b0;
							end else begin
								reload             = charge_q - 16'd1;
								pins_nxt.boost_low = 1'b1;
							end
						end
						default: reload = 16'd1;
					endcase
				end
			end
			scp_pkg::CMD_COMP: begin
				if (armed_q) begin
					armed_nxt = 1'b0;
					if (dual) begin
						meas_nxt = count_s1;
						reload   = count_s1 + (charge_q - 16'd1);
						written  = 1'b1;
					end else begin
						pins_nxt.boost_low = 1'b0;
						pins_nxt.cutoff    = 1'b0;
					end
				end
			end
			scp_pkg::CMD_BUTTON: begin
				if (phase_q == scp_pkg::PH_CHARGE) begin
					ext_nxt = scp_pkg::ButtonBaseTicks >> mode_q[4:2];
					reload  = count_s1 + ext_nxt;
					written = 1'b1;
				end
			end
			default: ;
		endcase
		reload = reload & scp_pkg::TimerMaskOut;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= scp_pkg::PH_INITIAL;
			toggle_q <= 1'b0;
			armed_q  <= 1'b0;
			ext_q    <= '0;
			meas_q   <= '0;
			acc_q    <= '0;
			pins_q   <= '0;
		end else if (step) begin
			phase_q  <= phase_nxt;
			toggle_q <= toggle_nxt;
			armed_q  <= armed_nxt;
			ext_q    <= ext_nxt;
			meas_q   <= meas_nxt;
			acc_q    <= acc_nxt;
			pins_q   <= pins_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_reload_q  <= reload;
			res_written_q <= written;
			res_pins_q    <= pins_nxt;
			res_armed_q   <= armed_nxt;
			res_phase_q   <= phase_nxt;
		end
	end

	assign result_valid   = res_valid_q;
	assign reload_value   = res_reload_q;
	assign reload_written = res_written_q;
	assign gate_a         = res_pins_q.gate_a;
	assign gate_b         = res_pins_q.gate_b;
	assign boost_low      = res_pins_q.boost_low;
	assign boost_high     = res_pins_q.boost_high;
	assign cutoff         = res_pins_q.cutoff;
	assign comparator_on  = res_armed_q;
	assign phase          = res_phase_q;

	`SCP_ASSERT(a_stall_needs_item, item_stall |-> valid_s1 && res_valid_q, "stall while free")
	`SCP_ASSERT(a_item_kept, valid_s1 && !advance |=> valid_s1, "held item lost")
	`SCP_ASSERT(a_no_write_zero, result_valid && !reload_written |-> reload_value == 16'd0, "stray reload")
	`SCP_ASSERT(a_no_return_initial, phase_q != scp_pkg::PH_INITIAL |=> phase_q != scp_pkg::PH_INITIAL, "back to initial")
	`SCP_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !res_valid_q && !valid_s1, "not empty in reset")

endmodule

[bench/slave_clock_pulse_sequencer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slave clock pulse sequencer checker
// Watches the item, result and register write ports of the sequencer. For
// every accepted item it steps its own copy of the phase machine and queues
// the expected result. Every accepted result is compared field by field with
// the oldest queued one.
// ----------------------------------------------------------------------------
module slave_clock_pulse_sequencer_checker
	import scp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        item_valid,
	input  logic        item_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] timer_count,
	input  logic        result_valid,
	input  logic        result_stall,
	input  logic [15:0] reload_value,
	input  logic        reload_written,
	input  logic        gate_a,
	input  logic        gate_b,
	input  logic        boost_low,
	input  logic        boost_high,
	input  logic        cutoff,
	input  logic        comparator_on,
	input  logic [1:0]  phase,
	output int          pending,
	output int          mismatches
);

	typedef struct packed {
		logic [15:0] reload_value;
		logic        reload_written;
		pins_t       pins;
		logic        comparator_on;
		phase_t      phase;
	} step_result_t;

	step_result_t expected_steps[$];

	// Settings as the sequencer holds them.
	logic [15:0] period_q, pulse_q, charge_q, trim_period_q, trim_step_q, trim_offset_q;
	logic [1:0]  trim_sign_q;
	logic [4:0]  mode_q;

	// Sequencer state.
	phase_t      phase_q;
	logic        toggle_q;
	logic        armed_q;
	logic [15:0] button_ticks;
	logic [15:0] charge_count;
	logic [16:0] trim_acc;
	pins_t       pin_q;

	task automatic reset_sequencer();
		period_q      = PeriodReset;
		pulse_q       = PulseReset;
		charge_q      = '0;
		trim_period_q = '0;
		trim_step_q   = '0;
		trim_offset_q = '0;
		trim_sign_q   = '0;
		mode_q        = ModeReset;
		phase_q       = PH_INITIAL;
		toggle_q      = 1'b0;
		armed_q       = 1'b0;
		button_ticks  = '0;
		charge_count  = '0;
		trim_acc      = '0;
		pin_q         = '0;
	endtask

	task automatic write_setting(input logic [2:0] idx, input logic [15:0] d);
		case (idx)
		REG_PERIOD:      period_q = d;
		REG_PULSE:       pulse_q = d;
		REG_CHARGE:      charge_q = d;
		REG_TRIM_PERIOD: trim_period_q = d;
		REG_TRIM_STEP:   trim_step_q = d;
		REG_TRIM_OFFSET: trim_offset_q = d;
		REG_TRIM_SIGN:   trim_sign_q = d[1:0];
		REG_MODE:        mode_q = d[4:0];
		default: ;
		endcase
	endtask

	// Constant offset plus the signed trim tick whenever the accumulator wraps.
	// The sum is formed wider than the accumulator so a stale value still compares right.
	function automatic logic [15:0] trim_shift();
		logic [17:0] sum;
		logic [15:0] shift;
		shift = trim_offset_q;
		if (trim_period_q != '0) begin
			sum = {1'b0, trim_acc} + {2'b00, trim_step_q};
			if (sum >= {2'b00, trim_period_q}) begin
				sum = sum - {2'b00, trim_period_q};
				shift = shift + {{14{trim_sign_q[1]}}, trim_sign_q};
			end
			trim_acc = sum[16:0];
		end
		return shift;
	endfunction

	function automatic void fire_gate();
		if (!mode_q[1]) begin
			pin_q.gate_a = 1'b1;
		end else begin
			if (toggle_q)
				pin_q.gate_a = 1'b1;
			else
				pin_q.gate_b = 1'b1;
			toggle_q = !toggle_q;
		end
	endfunction

	function automatic logic [15:0] step_single_cell();
		logic [15:0] shift;
		logic [15:0] r;
		r = 16'd1;
		case (phase_q)
		PH_IDLE: begin
			pin_q.gate_a = 1'b0;
			pin_q.gate_b = 1'b0;
			pin_q.boost_low = 1'b1;
			armed_q = 1'b1;
			shift = trim_shift();
			r = period_q - pulse_q - charge_q - button_ticks - 16'd1 + shift;
			button_ticks = '0;
			phase_q = PH_CHARGE;
		end
		PH_CHARGE, PH_PULSE: begin
			// A zero charge length skips straight on to the pulse.
			if (phase_q == PH_CHARGE && charge_q != '0) begin
				pin_q.boost_low = 1'b1;
				phase_q = PH_PULSE;
				r = charge_q - 16'd1;
			end else begin
				pin_q.cutoff = 1'b1;
				pin_q.boost_low = 1'b0;
				fire_gate();
				phase_q = PH_IDLE;
				r = pulse_q - 16'd1;
			end
		end
		default: begin
			phase_q = PH_IDLE;
		end
		endcase
		return r;
	endfunction

	function automatic logic [15:0] step_dual_cell();
		logic [15:0] shift;
		logic [15:0] r;
		r = 16'd1;
		case (phase_q)
		PH_IDLE: begin
			pin_q.gate_a = 1'b0;
			pin_q.gate_b = 1'b0;
			shift = trim_shift();
			r = period_q - pulse_q - charge_q - button_ticks - charge_count - 16'd1 + shift;
			button_ticks = '0;
			phase_q = PH_CHARGE;
		end
		PH_CHARGE: begin
			armed_q = 1'b1;
			pin_q.cutoff = 1'b1;
			pin_q.boost_high = 1'b0;
			phase_q = PH_PULSE;
			r = TimerMaskOut;
		end
		PH_PULSE: begin
			armed_q = 1'b0;
			pin_q.boost_high = 1'b1;
			pin_q.cutoff = 1'b0;
			fire_gate();
			phase_q = PH_IDLE;
			r = pulse_q - 16'd1;
		end
		default: begin
			phase_q = PH_CHARGE;
		end
		endcase
		return r;
	endfunction

	function automatic step_result_t predict_step(input logic [1:0] c, input logic [15:0] cnt);
		step_result_t res;
		res.reload_value = '0;
		res.reload_written = 1'b0;
		case (c)
		CMD_TIMER: begin
			res.reload_value = mode_q[0] ? step_dual_cell() : step_single_cell();
			res.reload_written = 1'b1;
		end
		CMD_COMP: begin
			if (armed_q) begin
				armed_q = 1'b0;
				if (!mode_q[0]) begin
					pin_q.boost_low = 1'b0;
					pin_q.cutoff = 1'b0;
				end else begin
					charge_count = cnt;
					res.reload_value = cnt + charge_q - 16'd1;
					res.reload_written = 1'b1;
				end
			end
		end
		CMD_BUTTON: begin
			if (phase_q == PH_CHARGE) begin
				button_ticks = ButtonBaseTicks >> mode_q[4:2];
				res.reload_value = cnt + button_ticks;
				res.reload_written = 1'b1;
			end
		end
		default: ;
		endcase
		res.pins = pin_q;
		res.comparator_on = armed_q;
		res.phase = phase_q;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic check_result();
		step_result_t want;
		if (expected_steps.size() == 0) begin
			report_mismatch("result with no item waiting, reload_value", reload_value, 0);
		end else begin
			want = expected_steps.pop_front();
			if (reload_value !== want.reload_value)
				report_mismatch("reload_value", reload_value, want.reload_value);
			if (reload_written !== want.reload_written)
				report_mismatch("reload_written", reload_written, want.reload_written);
			if (gate_a !== want.pins.gate_a)
				report_mismatch("gate_a", gate_a, want.pins.gate_a);
			if (gate_b !== want.pins.gate_b)
				report_mismatch("gate_b", gate_b, want.pins.gate_b);
			if (boost_low !== want.pins.boost_low)
				report_mismatch("boost_low", boost_low, want.pins.boost_low);
			if (boost_high !== want.pins.boost_high)
				report_mismatch("boost_high", boost_high, want.pins.boost_high);
			if (cutoff !== want.pins.cutoff)
				report_mismatch("cutoff", cutoff, want.pins.cutoff);
			if (comparator_on !== want.comparator_on)
				report_mismatch("comparator_on", comparator_on, want.comparator_on);
			if (phase !== want.phase)
				report_mismatch("phase", phase, want.phase);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_sequencer();
			expected_steps.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (result_valid && !result_stall)
				check_result();
			if (item_valid && !item_stall)
				expected_steps.push_back(predict_step(cmd, timer_count));
			if (cfg_we)
				write_setting(cfg_index, cfg_data);
			pending <= expected_steps.size();
		end
	end

endmodule

[bench/slave_clock_pulse_sequencer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slave clock pulse sequencer testbench
// Drives directed and random event items into the sequencer under a series
// of register settings, with random gaps on the item side and random stalls
// on the result side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module slave_clock_pulse_sequencer_tb;
	import scp_pkg::*;

	localparam logic [1:0] CmdUnknown    = 2'd3;
	localparam logic [4:0] ModeDual      = 5'b00001;
	localparam logic [4:0] ModeAlternate = 5'b00010;
	localparam int         NumPhases     = 14;
	localparam int         ItemsPerPhase = 138;
	localparam int         CycleLimit    = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_PERIOD;
	logic [15:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic [1:0]  cmd = CMD_TIMER;
	logic [15:0] timer_count = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [15:0] reload_value;
	logic        reload_written;
	logic        gate_a;
	logic        gate_b;
	logic        boost_low;
	logic        boost_high;
	logic        cutoff;
	logic        comparator_on;
	logic [1:0]  phase;

	int          pending;
	int          mismatches;
	int unsigned gap_max = 7;
	int unsigned stall_max = 7;
	int unsigned stall_left = 0;
	int unsigned stall_draw;
	int unsigned cycle_count = 0;

	slave_clock_pulse_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.cmd           (cmd),
		.timer_count   (timer_count),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.reload_value  (reload_value),
		.reload_written(reload_written),
		.gate_a        (gate_a),
		.gate_b        (gate_b),
		.boost_low     (boost_low),
		.boost_high    (boost_high),
		.cutoff        (cutoff),
		.comparator_on (comparator_on),
		.phase         (phase)
	);

	slave_clock_pulse_sequencer_checker seq_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.cmd           (cmd),
		.timer_count   (timer_count),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.reload_value  (reload_value),
		.reload_written(reload_written),
		.gate_a        (gate_a),
		.gate_b        (gate_b),
		.boost_low     (boost_low),
		.boost_high    (boost_high),
		.cutoff        (cutoff),
		.comparator_on (comparator_on),
		.phase         (phase),
		.pending       (pending),
		.mismatches    (mismatches)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("slave_clock_pulse_sequencer_tb failed");
			$finish;
		end
	end

	// Result side: after each accepted result, stall for a random number of cycles.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			if (stall_left == 1)
				result_stall <= 1'b0;
		end else if (result_valid && !result_stall) begin
			stall_draw = $urandom_range(0, stall_max);
			if (stall_draw != 0) begin
				result_stall <= 1'b1;
				stall_left <= stall_draw;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [15:0] period, input logic [15:0] pulse,
			input logic [15:0] charge, input logic [15:0] trim_period,
			input logic [15:0] trim_step, input logic [15:0] trim_offset,
			input logic [1:0] trim_sign, input logic [4:0] mode);
		write_reg(REG_PERIOD, period);
		write_reg(REG_PULSE, pulse);
		write_reg(REG_CHARGE, charge);
		write_reg(REG_TRIM_PERIOD, trim_period);
		write_reg(REG_TRIM_STEP, trim_step);
		write_reg(REG_TRIM_OFFSET, trim_offset);
		write_reg(REG_TRIM_SIGN, {14'd0, trim_sign});
		write_reg(REG_MODE, {11'd0, mode});
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(input logic [1:0] c, input logic [15:0] cnt);
		int unsigned gap;
		gap = $urandom_range(0, gap_max);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd <= c;
		timer_count <= cnt;
		do @(posedge clk); while (item_stall);
	endtask

	// Holds off the sender until every queued result has come back.
	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 9))
		0: return 16'h0000;
		1: return 16'h0001;
		2: return 16'h7FFF;
		3: return 16'h8000;
		4: return 16'hFFFF;
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_trim_period();
		case ($urandom_range(0, 5))
		0: return 16'h0000;
		1: return 16'h0001;
		2, 3: return 16'($urandom_range(1, 40));
		default: return pick_value();
		endcase
	endfunction

	function automatic logic [1:0] pick_cmd();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return CMD_TIMER;
		else if (r < 77)
			return CMD_COMP;
		else if (r < 95)
			return CMD_BUTTON;
		else
			return CmdUnknown;
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Either the single-cell or the dual-cell start-up step is taken first.
		if ($urandom_range(0, 1) == 1) begin
			write_reg(REG_MODE, {11'd0, ModeReset | ModeDual});
			cfg_we <= 1'b0;
		end

		// Ignored commands, then a full cycle under the reset settings.
		send_item(CmdUnknown, 16'h1234);
		send_item(CMD_COMP, 16'h0000);
		send_item(CMD_BUTTON, 16'hFFFF);
		send_item(CMD_TIMER, 16'h0000);
		send_item(CMD_TIMER, 16'h0000);
		send_item(CMD_BUTTON, 16'hFFFF);
		send_item(CMD_COMP, 16'hFFFF);
		send_item(CMD_TIMER, 16'h0000);
		send_item(CMD_TIMER, 16'hFFFF);
		send_item(CMD_TIMER, 16'h0000);
		wait_drained();

		// Extreme settings: wrapping lengths, a stale accumulator and the minus two trim.
		load_settings(16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h8000, 2'b10,
			ModeDual | ModeAlternate);
		send_item(CMD_TIMER, 16'h0000);
		send_item(CMD_BUTTON, 16'hFFFF);
		send_item(CMD_TIMER, 16'hFFFF);
		send_item(CMD_COMP, 16'hFFFF);
		send_item(CMD_COMP, 16'h0000);
		send_item(CMD_TIMER, 16'h0000);
		send_item(CMD_TIMER, 16'h0000);
		send_item(CMD_TIMER, 16'h0000);
		send_item(CMD_COMP, 16'h0000);
		send_item(CMD_TIMER, 16'h0000);
		send_item(CMD_BUTTON, 16'h0000);
		send_item(CmdUnknown, 16'hFFFF);

		for (int p = 0; p < NumPhases; p++) begin
			wait_drained();
			if (p == NumPhases - 1)
				load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF,
					2'b01, 5'h1F);
			else
				load_settings(pick_value(), pick_value(),
					($urandom_range(0, 2) == 0) ? 16'h0000 : pick_value(),
					pick_trim_period(), pick_value(), pick_value(),
					2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
			stall_max <= ($urandom_range(0, 3) == 0) ? 0 : 7;
			for (int i = 0; i < ItemsPerPhase; i++)
				send_item(pick_cmd(), pick_value());
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("slave_clock_pulse_sequencer_tb passed");
		else
			$display("slave_clock_pulse_sequencer_tb failed");
		$finish;
	end

endmodule
